// ===== sv/shani_pkg.sv =====
// Shared types, constants and round functions for the SHA instruction unit.
// Used by shani_front, shani_back and sha_ni_execute_unit; no dependencies.
`default_nettype none

package shani_pkg;

  typedef logic [31:0] word_t;

  // Operation codes carried on operation_i
  typedef enum logic [2:0] {
    OP_SHA1RNDS4   = 3'd0,
    OP_SHA1NEXTE   = 3'd1,
    OP_SHA1MSG1    = 3'd2,
    OP_SHA1MSG2    = 3'd3,
    OP_SHA256RNDS2 = 3'd4,
    OP_SHA256MSG1  = 3'd5,
    OP_SHA256MSG2  = 3'd6,
    OP_INVALID     = 3'd7
  } op_e;

  // SHA-1 round constants, one per round group
  localparam word_t Sha1K0 = 32'h5a827999;
  localparam word_t Sha1K1 = 32'h6ed9eba1;
  localparam word_t Sha1K2 = 32'h8f1bbcdc;
  localparam word_t Sha1K3 = 32'hca62c1d6;

  typedef struct packed {
    word_t a;
    word_t b;
    word_t c;
    word_t d;
    word_t e;
  } sha1_st_t;

  typedef struct packed {
    word_t a;
    word_t b;
    word_t c;
    word_t d;
    word_t e;
    word_t f;
    word_t g;
    word_t h;
  } sha256_st_t;

  // Captured input item
  typedef struct packed {
    op_e              op;
    logic [1:0]       sel;
    logic [3:0][31:0] dst;
    logic [3:0][31:0] src;
    word_t            k0;
    word_t            k1;
  } in_t;

  // Item between the two round halves
  typedef struct packed {
    op_e              op;
    logic [1:0]       sel;
    sha1_st_t         st1;
    sha256_st_t       st2;
    word_t            aux0;
    word_t            aux1;
    logic [3:0][31:0] res;
  } mid_t;

  // Finished result
  typedef struct packed {
    logic [3:0][31:0] res;
    logic             vld;
  } res_t;

  function automatic word_t rotr(word_t x, int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t rotl(word_t x, int unsigned n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic word_t small_sig0(word_t x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t small_sig1(word_t x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic word_t big_sum0(word_t x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t big_sum1(word_t x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic word_t choose(word_t x, word_t y, word_t z);
    return (x & y) ^ (~x & z);
  endfunction

  function automatic word_t majority(word_t x, word_t y, word_t z);
    return (x & y) ^ (x & z) ^ (y & z);
  endfunction

  // SHA-1 round function by round group
  function automatic word_t sha1_fn(logic [1:0] sel, word_t b, word_t c, word_t d);
    word_t f;
    unique case (sel)
      2'd0:    f = choose(b, c, d);
      2'd2:    f = majority(b, c, d);
      default: f = b ^ c ^ d;
    endcase
    return f;
  endfunction

  function automatic word_t sha1_k(logic [1:0] sel);
    word_t k;
    unique case (sel)
      2'd0:    k = Sha1K0;
      2'd1:    k = Sha1K1;
      2'd2:    k = Sha1K2;
      default: k = Sha1K3;
    endcase
    return k;
  endfunction

  // One SHA-1 round with message word w
  function automatic sha1_st_t sha1_round(sha1_st_t st, word_t w, logic [1:0] sel);
    sha1_st_t n;
    n.a = sha1_fn(sel, st.b, st.c, st.d) + rotl(st.a, 5) + w + sha1_k(sel) + st.e;
    n.b = st.a;
    n.c = rotl(st.b, 30);
    n.d = st.c;
    n.e = st.d;
    return n;
  endfunction

  // One SHA-256 round with key-plus-message word kw
  function automatic sha256_st_t sha256_round(sha256_st_t st, word_t kw);
    sha256_st_t n;
    word_t      t1;
    word_t      t2;
    t1 = choose(st.e, st.f, st.g) + big_sum1(st.e) + kw + st.h;
    t2 = majority(st.a, st.b, st.c) + big_sum0(st.a);
    n.h = st.g;
    n.g = st.f;
    n.f = st.e;
    n.e = st.d + t1;
    n.d = st.c;
    n.c = st.b;
    n.b = st.a;
    n.a = t1 + t2;
    return n;
  endfunction

endpackage

`default_nettype wire

// ===== sv/shani_front.sv =====
// First half of the SHA unit: two SHA-1 rounds, one SHA-256 round and the
// message-schedule and next-E operations. Depends on shani_pkg.
`default_nettype none

module shani_front (
  input  shani_pkg::in_t  item_i,
  output shani_pkg::mid_t mid_o
);

  shani_pkg::sha1_st_t   s1_init;
  shani_pkg::sha1_st_t   s1_r0;
  shani_pkg::sha256_st_t s2_init;
  shani_pkg::word_t      w16;
  shani_pkg::word_t      w17;
  logic [3:0][31:0]      res;

  // Load the working variables from the register words
  always_comb begin
    s1_init.a = item_i.dst[3];
    s1_init.b = item_i.dst[2];
    s1_init.c = item_i.dst[1];
    s1_init.d = item_i.dst[0];
    s1_init.e = '0;

    s2_init.a = item_i.src[3];
    s2_init.b = item_i.src[2];
    s2_init.c = item_i.dst[3];
    s2_init.d = item_i.dst[2];
    s2_init.e = item_i.src[1];
    s2_init.f = item_i.src[0];
    s2_init.g = item_i.dst[1];
    s2_init.h = item_i.dst[0];
  end

  // Run the first rounds
  assign s1_r0       = shani_pkg::sha1_round(s1_init, item_i.src[3], item_i.sel);
  assign mid_o.st1   = shani_pkg::sha1_round(s1_r0, item_i.src[2], item_i.sel);
  assign mid_o.st2   = shani_pkg::sha256_round(s2_init, item_i.k0);

  // Schedule words shared by the SHA-256 second schedule step
  assign w16 = item_i.dst[0] + shani_pkg::small_sig1(item_i.src[2]);
  assign w17 = item_i.dst[1] + shani_pkg::small_sig1(item_i.src[3]);

  // Finish the single-step operations here
  always_comb begin
    res = item_i.dst;
    unique case (item_i.op)
      shani_pkg::OP_SHA1NEXTE: begin
        res[3] = item_i.src[3] + shani_pkg::rotl(item_i.dst[3], 30);
        res[2] = item_i.src[2];
        res[1] = item_i.src[1];
        res[0] = item_i.src[0];
      end
      shani_pkg::OP_SHA1MSG1: begin
        res[3] = item_i.dst[1] ^ item_i.dst[3];
        res[2] = item_i.dst[0] ^ item_i.dst[2];
        res[1] = item_i.src[3] ^ item_i.dst[1];
        res[0] = item_i.src[2] ^ item_i.dst[0];
      end
      shani_pkg::OP_SHA1MSG2: begin
        res[3] = shani_pkg::rotl(item_i.dst[3] ^ item_i.src[2], 1);
        res[2] = shani_pkg::rotl(item_i.dst[2] ^ item_i.src[1], 1);
        res[1] = shani_pkg::rotl(item_i.dst[1] ^ item_i.src[0], 1);
        res[0] = shani_pkg::rotl(item_i.dst[0] ^
                                 shani_pkg::rotl(item_i.dst[3] ^ item_i.src[2], 1), 1);
      end
      shani_pkg::OP_SHA256MSG1: begin
        res[3] = item_i.dst[3] + shani_pkg::small_sig0(item_i.src[0]);
        res[2] = item_i.dst[2] + shani_pkg::small_sig0(item_i.dst[3]);
        res[1] = item_i.dst[1] + shani_pkg::small_sig0(item_i.dst[2]);
        res[0] = item_i.dst[0] + shani_pkg::small_sig0(item_i.dst[1]);
      end
      shani_pkg::OP_SHA256MSG2: begin
        res[0] = w16;
        res[1] = w17;
        res[2] = item_i.dst[2] + shani_pkg::small_sig1(w16);
        res[3] = item_i.dst[3] + shani_pkg::small_sig1(w17);
      end
      default: res = item_i.dst;
    endcase
  end

  // Hand on the words the second half still needs
  assign mid_o.op   = item_i.op;
  assign mid_o.sel  = item_i.sel;
  assign mid_o.aux0 = (item_i.op == shani_pkg::OP_SHA256RNDS2) ? item_i.k1 : item_i.src[1];
  assign mid_o.aux1 = item_i.src[0];
  assign mid_o.res  = res;

endmodule

`default_nettype wire

// ===== sv/shani_back.sv =====
// Second half of the SHA unit: last two SHA-1 rounds, second SHA-256 round
// and the final result select. Depends on shani_pkg.
`default_nettype none

module shani_back (
  input  shani_pkg::mid_t mid_i,
  output shani_pkg::res_t res_o
);

  shani_pkg::sha1_st_t   s1_r2;
  shani_pkg::sha1_st_t   s1_r3;
  shani_pkg::sha256_st_t s2_r1;

  // Run the remaining rounds
  assign s1_r2 = shani_pkg::sha1_round(mid_i.st1, mid_i.aux0, mid_i.sel);
  assign s1_r3 = shani_pkg::sha1_round(s1_r2, mid_i.aux1, mid_i.sel);
  assign s2_r1 = shani_pkg::sha256_round(mid_i.st2, mid_i.aux0);

  // Pick the new destination words
  always_comb begin
    res_o.res = mid_i.res;
    unique case (mid_i.op)
      shani_pkg::OP_SHA1RNDS4: begin
        res_o.res[3] = s1_r3.a;
        res_o.res[2] = s1_r3.b;
        res_o.res[1] = s1_r3.c;
        res_o.res[0] = s1_r3.d;
      end
      shani_pkg::OP_SHA256RNDS2: begin
        res_o.res[3] = s2_r1.a;
        res_o.res[2] = s2_r1.b;
        res_o.res[1] = s2_r1.e;
        res_o.res[0] = s2_r1.f;
      end
      default: res_o.res = mid_i.res;
    endcase
  end

  assign res_o.vld = (mid_i.op != shani_pkg::OP_INVALID);

endmodule

`default_nettype wire

// ===== sv/sha_ni_execute_unit.sv =====
// Top level of the SHA instruction execution unit: three-stage pipeline.
// Depends on shani_pkg, shani_front and shani_back.
//
//   channel | handshake                 | payload
//   --------+---------------------------+-----------------------------------------
//   input   | in_valid_i / in_stall_o   | operation, round_group, dest, src, key
//   output  | out_valid_o / out_stall_i | result_word0..3, valid_res
//
// One transfer per cycle sustained while the output is not stalled; a result
// passes through the input register, mid register and output register in
// that order before it is presented.
// The SHA-1 four-round step is split two rounds per half, which sets the
// depth between registers. All stages advance together whenever the output
// register is empty or being taken; otherwise the whole pipe holds.
// Reset clears the stage valid bits only; no state links items.
`default_nettype none

module sha_ni_execute_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,

  input  wire logic        in_valid_i,
  output      logic        in_stall_o,
  input  wire logic [2:0]  operation_i,
  input  wire logic [1:0]  round_group_i,
  input  wire logic [31:0] dest_word0_i,
  input  wire logic [31:0] dest_word1_i,
  input  wire logic [31:0] dest_word2_i,
  input  wire logic [31:0] dest_word3_i,
  input  wire logic [31:0] src_word0_i,
  input  wire logic [31:0] src_word1_i,
  input  wire logic [31:0] src_word2_i,
  input  wire logic [31:0] src_word3_i,
  input  wire logic [31:0] key_word0_i,
  input  wire logic [31:0] key_word1_i,

  output      logic        out_valid_o,
  input  wire logic        out_stall_i,
  output      logic [31:0] result_word0_o,
  output      logic [31:0] result_word1_o,
  output      logic [31:0] result_word2_o,
  output      logic [31:0] result_word3_o,
  output      logic        valid_res_o
);

  logic             adv;
  shani_pkg::in_t   in_d;
  shani_pkg::in_t   in_q;
  logic             in_vld_q;
  shani_pkg::mid_t  mid_d;
  shani_pkg::mid_t  mid_q;
  logic             mid_vld_q;
  shani_pkg::res_t  res_d;
  shani_pkg::res_t  res_q;
  logic             res_vld_q;

  // Advance the pipe unless the output holds an untaken result
  assign adv        = !res_vld_q || !out_stall_i;
  assign in_stall_o = !adv;

  // Pack the input transfer
  always_comb begin
    in_d.op     = shani_pkg::op_e'(operation_i);
    in_d.sel    = round_group_i;
    in_d.dst[0] = dest_word0_i;
    in_d.dst[1] = dest_word1_i;
    in_d.dst[2] = dest_word2_i;
    in_d.dst[3] = dest_word3_i;
    in_d.src[0] = src_word0_i;
    in_d.src[1] = src_word1_i;
    in_d.src[2] = src_word2_i;
    in_d.src[3] = src_word3_i;
    in_d.k0     = key_word0_i;
    in_d.k1     = key_word1_i;
  end

  shani_front u_front (
    .item_i (in_q),
    .mid_o  (mid_d)
  );

  shani_back u_back (
    .mid_i (mid_q),
    .res_o (res_d)
  );

  // Stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      mid_vld_q <= 1'b0;
      res_vld_q <= 1'b0;
    end else if (adv) begin
      in_vld_q  <= in_valid_i;
      mid_vld_q <= in_vld_q;
      res_vld_q <= mid_vld_q;
    end
  end

  // Stage payloads
  always_ff @(posedge clk_i) begin
    if (adv) begin
      in_q  <= in_d;
      mid_q <= mid_d;
      res_q <= res_d;
    end
  end

  assign out_valid_o    = res_vld_q;
  assign result_word0_o = res_q.res[0];
  assign result_word1_o = res_q.res[1];
  assign result_word2_o = res_q.res[2];
  assign result_word3_o = res_q.res[3];
  assign valid_res_o    = res_q.vld;

endmodule

`default_nettype wire
